>>> hdl/dshot_frame_encoder_unit_assert.svh
// Assertion macros for the DShot frame encoder.
`ifndef DSHOT_FRAME_ENCODER_UNIT_ASSERT_SVH
`define DSHOT_FRAME_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define DFE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("dshot frame encoder: check failed");

// Next-cycle implication, disabled while in reset.
`define DFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("dshot frame encoder: check failed");

`endif

>>> hdl/dfe_pkg.sv
// Types and constants shared by the DShot frame encoder.
`default_nettype none
package dfe_pkg;

	localparam int FRAME_BITS = 16;
	localparam int SYM_IDX_W  = 5;
	localparam logic [10:0] THROTTLE_LOWEST = 11'd48;

	localparam logic [7:0]  RST_BIT_PERIOD = 8'd19;
	localparam logic [7:0]  RST_ONE_HIGH   = 8'd14;
	localparam logic [7:0]  RST_ZERO_HIGH  = 8'd7;
	localparam logic [14:0] RST_PAUSE      = 15'd3800;

	typedef enum logic {
		OP_THROTTLE = 1'b0,
		OP_COMMAND  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		REG_BIT_PERIOD = 2'd0,
		REG_ONE_HIGH   = 2'd1,
		REG_ZERO_HIGH  = 2'd2,
		REG_PAUSE      = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0]  bit_period;
		logic [7:0]  one_high;
		logic [7:0]  zero_high;
		logic [14:0] pause;
	} cfg_t;

	typedef struct packed {
		logic                  err;
		logic [FRAME_BITS-1:0] frame;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic busy;
	} back_status_t;

endpackage
`default_nettype wire

>>> hdl/dfe_in_if.sv
// Request channel carrying one frame request per transaction.
`default_nettype none
interface dfe_in_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [10:0] frame_value;
	logic        telemetry_request;

	modport source(output valid, output opcode, output frame_value,
		output telemetry_request, input ready);
	modport sink(input valid, input opcode, input frame_value,
		input telemetry_request, output ready);
endinterface
`default_nettype wire

>>> hdl/dfe_out_if.sv
// Symbol channel carrying one pulse symbol per transaction.
`default_nettype none
interface dfe_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  high_ticks;
	logic [14:0] low_ticks;
	logic        last_symbol;
	logic        range_error;

	modport source(output valid, output high_ticks, output low_ticks,
		output last_symbol, output range_error, input ready);
	modport sink(input valid, input high_ticks, input low_ticks,
		input last_symbol, input range_error, output ready);
endinterface
`default_nettype wire

>>> hdl/dshot_frame_encoder_unit.sv
// DShot frame encoder top level: configuration registers, front end, queue, back end.
//
// in_ch carries frame requests (opcode, frame_value, telemetry_request); out_ch
// carries pulse symbols (high_ticks, low_ticks, last_symbol, range_error).
// Transactions complete where valid and ready are both high.
// A valid frame yields 16 bit symbols, MSB first, then a pause symbol with
// last_symbol set. A throttle below 48 yields one error symbol instead.
// A request passes through the queue and then the output register of the back end.
// Throughput: one symbol per cycle while out_ch is ready, set by the single output
// register of the back end. The front end takes requests into a queue of
// QUEUE_DEPTH entries and keeps accepting while the back end is busy.
// A stall on out_ch holds the output symbol; once the queue fills, in_ch
// ready falls. Reset clears the queue, the back end and the output valid, and
// loads the register defaults (19, 14, 7, 3800). cfg_we writes register
// cfg_index; write only while the block is idle.
`default_nettype none
`include "dshot_frame_encoder_unit_assert.svh"
module dshot_frame_encoder_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [14:0] cfg_data,
	dfe_in_if.sink           in_ch,
	dfe_out_if.source        out_ch
);
	dfe_pkg::cfg_t         cfg_q;
	dfe_pkg::entry_t       push_entry;
	dfe_pkg::entry_t       head;
	dfe_pkg::q_status_t    q_status;
	dfe_pkg::back_status_t back_status;
	logic                  pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bit_period <= dfe_pkg::RST_BIT_PERIOD;
			cfg_q.one_high <= dfe_pkg::RST_ONE_HIGH;
			cfg_q.zero_high <= dfe_pkg::RST_ZERO_HIGH;
			cfg_q.pause <= dfe_pkg::RST_PAUSE;
		end else if (cfg_we) begin
			unique case (dfe_pkg::cfg_reg_t'(cfg_index))
				dfe_pkg::REG_BIT_PERIOD: cfg_q.bit_period <= cfg_data[7:0];
				dfe_pkg::REG_ONE_HIGH:   cfg_q.one_high <= cfg_data[7:0];
				dfe_pkg::REG_ZERO_HIGH:  cfg_q.zero_high <= cfg_data[7:0];
				dfe_pkg::REG_PAUSE:      cfg_q.pause <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ch.ready = !q_status.full;

	dfe_front u_front (
		.opcode            (in_ch.opcode),
		.frame_value       (in_ch.frame_value),
		.telemetry_request (in_ch.telemetry_request),
		.entry             (push_entry)
	);

	dfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_ch.valid),
		.push_data (push_entry),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	dfe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.head     (head),
		.q_status (q_status),
		.pop      (pop),
		.status   (back_status),
		.out_ch   (out_ch)
	);

	`DFE_ASSERT_IMPL(a_error_shape, clk, arst_n,
		out_ch.valid && out_ch.range_error,
		out_ch.last_symbol && (out_ch.high_ticks == 8'd0) && (out_ch.low_ticks == 15'd0))
	`DFE_ASSERT_IMPL(a_pause_shape, clk, arst_n,
		out_ch.valid && out_ch.last_symbol && !out_ch.range_error,
		(out_ch.high_ticks == 8'd0) && (out_ch.low_ticks == cfg_q.pause))
	`DFE_ASSERT_NEXT(a_drain_idle, clk, arst_n,
		q_status.empty && !back_status.busy && out_ch.valid && out_ch.ready,
		!out_ch.valid)
endmodule
`default_nettype wire

>>> hdl/dfe_front.sv
// Front end: range check and frame assembly with checksum.
`default_nettype none
module dfe_front (
	input  wire logic           opcode,
	input  wire logic [10:0]    frame_value,
	input  wire logic           telemetry_request,
	output dfe_pkg::entry_t     entry
);
	logic [11:0] twelve;
	logic [3:0]  crc;

	always_comb begin
		twelve = {frame_value, telemetry_request};
		crc = twelve[3:0] ^ twelve[7:4] ^ twelve[11:8];
		entry.frame = {twelve, crc};
		entry.err = (dfe_pkg::opcode_t'(opcode) == dfe_pkg::OP_THROTTLE) &&
			(frame_value < dfe_pkg::THROTTLE_LOWEST);
	end
endmodule
`default_nettype wire

>>> hdl/dfe_queue.sv
// Short FIFO between the front end and the symbol generator.
`default_nettype none
module dfe_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire dfe_pkg::entry_t  push_data,
	input  wire logic             pop,
	output dfe_pkg::entry_t       head,
	output dfe_pkg::q_status_t    status
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	dfe_pkg::entry_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	always_comb begin
		status.full = (count_q == CNT_W'(DEPTH));
		status.empty = (count_q == '0);
		do_push = push && !status.full;
		do_pop = pop && !status.empty;
		head = mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end
endmodule
`default_nettype wire

>>> hdl/dfe_back.sv
// Back end: shifts frames out as pulse symbols into the output register.
`default_nettype none
module dfe_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire dfe_pkg::cfg_t         cfg,
	input  wire dfe_pkg::entry_t       head,
	input  wire dfe_pkg::q_status_t    q_status,
	output logic                       pop,
	output dfe_pkg::back_status_t      status,
	dfe_out_if.source                  out_ch
);
	logic                           busy_q;
	logic [dfe_pkg::FRAME_BITS-1:0] frame_shift_q;
	logic [dfe_pkg::SYM_IDX_W-1:0]  symbol_index_q;
	logic                           out_valid_q;
	logic [7:0]                     high_q;
	logic [14:0]                    low_q;
	logic                           last_q;
	logic                           err_q;

	logic       advance;
	logic       sym_bit;
	logic [7:0] bit_high;
	logic [7:0] bit_low;
	logic       at_pause;

	always_comb begin
		advance = !out_valid_q || out_ch.ready;
		sym_bit = busy_q ? frame_shift_q[dfe_pkg::FRAME_BITS-1]
			: head.frame[dfe_pkg::FRAME_BITS-1];
		bit_high = sym_bit ? cfg.one_high : cfg.zero_high;
		bit_low = (cfg.bit_period > bit_high) ? (cfg.bit_period - bit_high) : 8'd0;
		at_pause = (symbol_index_q == dfe_pkg::SYM_IDX_W'(dfe_pkg::FRAME_BITS));
		pop = advance && !busy_q && !q_status.empty;
		status.busy = busy_q;
		out_ch.valid = out_valid_q;
		out_ch.high_ticks = high_q;
		out_ch.low_ticks = low_q;
		out_ch.last_symbol = last_q;
		out_ch.range_error = err_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_valid_q <= 1'b0;
			frame_shift_q <= '0;
			symbol_index_q <= '0;
		end else if (advance) begin
			if (busy_q) begin
				out_valid_q <= 1'b1;
				if (at_pause) begin
					busy_q <= 1'b0;
					symbol_index_q <= symbol_index_q + 1'b1;
				end else begin
					frame_shift_q <= {frame_shift_q[dfe_pkg::FRAME_BITS-2:0], 1'b0};
					symbol_index_q <= symbol_index_q + 1'b1;
				end
			end else if (!q_status.empty) begin
				out_valid_q <= 1'b1;
				if (!head.err) begin
					busy_q <= 1'b1;
					frame_shift_q <= {head.frame[dfe_pkg::FRAME_BITS-2:0], 1'b0};
					symbol_index_q <= dfe_pkg::SYM_IDX_W'(1);
				end
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (busy_q && at_pause) begin
				high_q <= 8'd0;
				low_q <= cfg.pause;
				last_q <= 1'b1;
				err_q <= 1'b0;
			end else if (!busy_q && head.err) begin
				high_q <= 8'd0;
				low_q <= 15'd0;
				last_q <= 1'b1;
				err_q <= 1'b1;
			end else begin
				high_q <= bit_high;
				low_q <= {7'd0, bit_low};
				last_q <= 1'b0;
				err_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

>>> tb/dshot_frame_encoder_unit_checker.sv
// Symbol checker for the DShot frame encoder: predicts pulse symbols and compares them.
`default_nettype none
module dshot_frame_encoder_unit_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [14:0] cfg_data,
	dfe_in_if                in_ch,
	dfe_out_if               out_ch,
	output int               fail_count,
	output int               pending,
	output int               frames_seen,
	output int               rejects_seen,
	output int               symbols_seen
);
	import dfe_pkg::*;

	typedef struct packed {
		logic [7:0]  high_ticks;
		logic [14:0] low_ticks;
		logic        last_symbol;
		logic        range_error;
	} symbol_t;

	cfg_t    timing;
	symbol_t symbol_q[$];
	symbol_t want;
	symbol_t got;
	int      n_fail;
	int      n_frames;
	int      n_rejects;
	int      n_symbols;

	function automatic void predict_symbols(opcode_t op, logic [10:0] value, logic tel);
		logic [11:0] word;
		logic [15:0] frame;
		logic [7:0]  high;
		logic [14:0] low;
		if (op == OP_THROTTLE && value < THROTTLE_LOWEST) begin
			symbol_q.push_back('{8'd0, 15'd0, 1'b1, 1'b1});
			n_rejects++;
			return;
		end
		word  = {value, tel};
		frame = {word, word[11:8] ^ word[7:4] ^ word[3:0]};
		for (int k = FRAME_BITS - 1; k >= 0; k--) begin
			high = frame[k] ? timing.one_high : timing.zero_high;
			low  = (timing.bit_period > high) ? {7'd0, 8'(timing.bit_period - high)} : 15'd0;
			symbol_q.push_back('{high, low, 1'b0, 1'b0});
		end
		symbol_q.push_back('{8'd0, timing.pause, 1'b1, 1'b0});
		n_frames++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing    = '{RST_BIT_PERIOD, RST_ONE_HIGH, RST_ZERO_HIGH, RST_PAUSE};
			symbol_q.delete();
			n_fail    = 0;
			n_frames  = 0;
			n_rejects = 0;
			n_symbols = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_BIT_PERIOD: timing.bit_period = cfg_data[7:0];
					REG_ONE_HIGH:   timing.one_high   = cfg_data[7:0];
					REG_ZERO_HIGH:  timing.zero_high  = cfg_data[7:0];
					REG_PAUSE:      timing.pause      = cfg_data;
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				got = '{out_ch.high_ticks, out_ch.low_ticks, out_ch.last_symbol,
					out_ch.range_error};
				n_symbols++;
				if (symbol_q.size() == 0) begin
					n_fail++;
					if (n_fail <= 10)
						$display("unexpected symbol %0d: high %0d low %0d last %0b error %0b",
							n_symbols, got.high_ticks, got.low_ticks, got.last_symbol,
							got.range_error);
				end else begin
					want = symbol_q.pop_front();
					if (got.high_ticks !== want.high_ticks || got.low_ticks !== want.low_ticks ||
						got.last_symbol !== want.last_symbol ||
						got.range_error !== want.range_error) begin
						n_fail++;
						if (n_fail <= 10)
							$display("symbol %0d: expected %0d %0d %0b %0b, got %0d %0d %0b %0b",
								n_symbols, want.high_ticks, want.low_ticks, want.last_symbol,
								want.range_error, got.high_ticks, got.low_ticks,
								got.last_symbol, got.range_error);
					end
				end
			end
			if (in_ch.valid && in_ch.ready)
				predict_symbols(opcode_t'(in_ch.opcode), in_ch.frame_value,
					in_ch.telemetry_request);
		end
		fail_count   <= n_fail;
		pending      <= symbol_q.size();
		frames_seen  <= n_frames;
		rejects_seen <= n_rejects;
		symbols_seen <= n_symbols;
	end

endmodule
`default_nettype wire

>>> tb/dshot_frame_encoder_unit_test.sv
// Testbench top for the DShot frame encoder: clock, reset, stimulus and verdict.
`default_nettype none
module dshot_frame_encoder_unit_test;
	import dfe_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int LONG_STALL    = 300;
	localparam int SETTINGS      = 6;
	localparam int ITEMS_PER_SET = 38;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [14:0] cfg_data;
	int          fail_count;
	int          pending;
	int          frames_seen;
	int          rejects_seen;
	int          symbols_seen;
	int          cycle_count;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          stall_requests;

	dfe_in_if  in_ch();
	dfe_out_if out_ch();

	dshot_frame_encoder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	dshot_frame_encoder_unit_checker symbol_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_ch        (in_ch),
		.out_ch       (out_ch),
		.fail_count   (fail_count),
		.pending      (pending),
		.frames_seen  (frames_seen),
		.rejects_seen (rejects_seen),
		.symbols_seen (symbols_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("dshot_frame_encoder_unit_test: FAIL");
		$finish;
	end

	initial begin
		int stalls_served;
		stalls_served = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_requests != stalls_served) begin
				stalls_served++;
				out_ch.ready <= 1'b0;
				repeat (LONG_STALL - 1) @(posedge clk);
			end else begin
				out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_request(opcode_t op, logic [10:0] value, logic tel);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid             <= 1'b1;
		in_ch.opcode            <= op;
		in_ch.frame_value       <= value;
		in_ch.telemetry_request <= tel;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic send_random_request();
		opcode_t     op;
		logic [10:0] value;
		int          pick;
		op   = ($urandom_range(3) == 0) ? OP_COMMAND : OP_THROTTLE;
		pick = $urandom_range(99);
		if (pick < 15)
			value = 11'($urandom_range(47));
		else if (pick < 22)
			case ($urandom_range(3))
				0:       value = 11'd0;
				1:       value = 11'd47;
				2:       value = 11'd48;
				default: value = 11'd2047;
			endcase
		else
			value = 11'($urandom_range(2047));
		send_request(op, value, 1'($urandom_range(1)));
	endtask

	task automatic drain_symbols();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [14:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	task automatic apply_setting(int s);
		logic [7:0]  period;
		logic [7:0]  one_high;
		logic [7:0]  zero_high;
		logic [14:0] pause;
		case (s)
			1: begin
				period = 8'd1; one_high = 8'd255; zero_high = 8'd0; pause = 15'd0;
			end
			2: begin
				period = 8'd255; one_high = 8'd0; zero_high = 8'd255; pause = 15'd32767;
			end
			3: begin
				period = 8'd0; one_high = 8'd200; zero_high = 8'd1; pause = 15'd1;
			end
			4: begin
				period    = 8'($urandom_range(255));
				one_high  = 8'($urandom_range(255));
				zero_high = 8'($urandom_range(255));
				pause     = 15'($urandom_range(32767));
			end
			default: begin
				period    = 8'($urandom_range(1, 40));
				one_high  = 8'($urandom_range(40));
				zero_high = 8'($urandom_range(40));
				pause     = 15'($urandom_range(32767));
			end
		endcase
		write_reg(REG_BIT_PERIOD, {7'd0, period});
		write_reg(REG_ONE_HIGH, {7'd0, one_high});
		write_reg(REG_ZERO_HIGH, {7'd0, zero_high});
		write_reg(REG_PAUSE, pause);
		cfg_we <= 1'b0;
	endtask

	initial begin
		arst_n                  <= 1'b0;
		cfg_we                  <= 1'b0;
		cfg_index               <= REG_BIT_PERIOD;
		cfg_data                <= 15'd0;
		in_ch.valid             <= 1'b0;
		in_ch.opcode            <= OP_THROTTLE;
		in_ch.frame_value       <= 11'd0;
		in_ch.telemetry_request <= 1'b0;
		stall_requests          <= 0;
		recv_idle_pct           <= 66;
		send_idle_pct = 13;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// rejected throttles, range edges and raw commands under reset timing
		send_request(OP_THROTTLE, 11'd0, 1'b0);
		send_request(OP_THROTTLE, 11'd47, 1'b1);
		send_request(OP_THROTTLE, 11'd48, 1'b0);
		send_request(OP_THROTTLE, 11'd48, 1'b1);
		send_request(OP_THROTTLE, 11'd2047, 1'b1);
		send_request(OP_THROTTLE, 11'd1000, 1'b0);
		send_request(OP_COMMAND, 11'd0, 1'b0);
		send_request(OP_COMMAND, 11'd47, 1'b0);
		send_request(OP_COMMAND, 11'd2047, 1'b1);
		send_request(OP_COMMAND, 11'h555, 1'b1);
		send_request(OP_COMMAND, 11'h2aa, 1'b0);
		send_request(OP_THROTTLE, 11'd5, 1'b1);
		send_request(OP_THROTTLE, 11'h7aa, 1'b0);

		for (int s = 0; s < SETTINGS; s++) begin
			if (s > 0) begin
				drain_symbols();
				apply_setting(s);
			end
			if (s < 2) begin
				send_idle_pct = 13;
				recv_idle_pct <= 66;
			end else if (s < 4) begin
				send_idle_pct = 66;
				recv_idle_pct <= 13;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct <= 0;
			end
			for (int i = 0; i < ITEMS_PER_SET; i++) begin
				if (s == 4 && i == 10)
					stall_requests <= stall_requests + 1;
				if (i == 19)
					drain_symbols();
				send_random_request();
			end
		end

		drain_symbols();
		repeat (20) @(posedge clk);

		$display("covered %0d frames and %0d rejected throttles, %0d symbols checked",
			frames_seen, rejects_seen, symbols_seen);
		$display("six timing settings incl. saturated and zero bit periods, stalls both sides");
		if (fail_count == 0 && pending == 0)
			$display("dshot_frame_encoder_unit_test: PASS");
		else
			$display("dshot_frame_encoder_unit_test: FAIL");
		$finish;
	end

endmodule
`default_nettype wire

>>> sim.f
+incdir+hdl
hdl/dfe_pkg.sv
hdl/dfe_in_if.sv
hdl/dfe_out_if.sv
hdl/dfe_front.sv
hdl/dfe_queue.sv
hdl/dfe_back.sv
hdl/dshot_frame_encoder_unit.sv
tb/dshot_frame_encoder_unit_checker.sv
tb/dshot_frame_encoder_unit_test.sv
